FILE: rtl/rcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcp_pkg
// Shared types, register map and reset values of the relay channel protector.
// ----------------------------------------------------------------------------
package rcp_pkg;

	localparam int NUM_CH = 4;
	localparam int CH_W   = $clog2(NUM_CH);
	localparam int ADDR_W = 5;

	localparam logic [CH_W-1:0] CH_MIST = CH_W'(0);
	localparam logic [CH_W-1:0] CH_LAMP = CH_W'(1);
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CH - 1);

	localparam int unsigned MIST_LOCK_MS_DEF   = 600000;
	localparam bit          MIST_BYPASS_EN_DEF = 1'b1;

	localparam logic signed [11:0] TEMP_HIGH_RST    = 12'sd480;
	localparam logic signed [11:0] TEMP_LOW_RST     = 12'sd288;
	localparam logic [10:0]        HUM_HIGH_RST     = 11'd1520;
	localparam logic [10:0]        HUM_LOW_RST      = 11'd1280;
	localparam logic [30:0]        MAX_ON_RST       = 31'd180000;
	localparam logic [30:0]        COOLDOWN_RST     = 31'd30000;
	localparam logic [30:0]        MIN_ON_RST       = 31'd10000;
	localparam logic [30:0]        LAMP_LOCK_RST    = 31'd300000;

	typedef enum logic [2:0] {
		REG_TEMP_HIGH = 3'd0,
		REG_TEMP_LOW  = 3'd1,
		REG_HUM_HIGH  = 3'd2,
		REG_HUM_LOW   = 3'd3,
		REG_MAX_ON    = 3'd4,
		REG_COOLDOWN  = 3'd5,
		REG_MIN_ON    = 3'd6,
		REG_LAMP_LOCK = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic               fuzzy_on;
		logic signed [11:0] air_temp;
		logic               temp_valid;
		logic [10:0]        air_hum;
		logic               hum_valid;
		logic               mist_blackout;
		logic [3:0]         relay_request;
		logic [3:0]         latch_active;
		logic [3:0]         latch_force_on;
		logic [3:0]         cabinet_test;
	} tick_t;

	typedef struct packed {
		logic [3:0] relay_drive;
		logic [3:0] latch_clear;
		logic [3:0] lock_flags;
	} result_t;

	typedef struct packed {
		logic signed [11:0] temp_high;
		logic signed [11:0] temp_low;
		logic [10:0]        hum_high;
		logic [10:0]        hum_low;
		logic [30:0]        max_on_ms;
		logic [30:0]        cooldown_ms;
		logic [30:0]        min_on_ms;
		logic [30:0]        lamp_lock_ms;
	} cfg_t;

	typedef struct packed {
		logic        chan_on;
		logic [31:0] on_start;
		logic [31:0] lock_until;
		logic        hold_active;
		logic [31:0] hold_start;
	} chan_state_t;

	typedef struct packed {
		logic drive;
		logic clear;
		logic locked;
	} chan_res_t;

endpackage

FILE: rtl/rcp_chan_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcp_chan_eval
// Protection rule chain for one channel: takes the stored channel state and
// the tick, gives the next channel state and the channel's result bits.
// ----------------------------------------------------------------------------
module rcp_chan_eval #(
	parameter int unsigned MIST_LOCK_MS   = rcp_pkg::MIST_LOCK_MS_DEF,
	parameter bit          MIST_BYPASS_EN = rcp_pkg::MIST_BYPASS_EN_DEF
) (
	input  rcp_pkg::tick_t                 tick,
	input  logic [rcp_pkg::CH_W-1:0]       ch,
	input  rcp_pkg::cfg_t                  cfg,
	input  rcp_pkg::chan_state_t           cur,
	output rcp_pkg::chan_state_t           nxt,
	output rcp_pkg::chan_res_t             res
);

	logic        is_mist, is_lamp;
	logic        req, test, lact, keep_latch;
	logic        blackout, locked, over, under, over_kill;
	logic [31:0] lock_len, lock_d, new_d;
	logic        hold_en, hold_short, max_hit;
	logic        on1, on2;
	rcp_pkg::chan_state_t idle, norm;
	logic        norm_drive, norm_clear;
	logic        res_drive, res_clear, res_lock;

	assign is_mist    = (ch == rcp_pkg::CH_MIST);
	assign is_lamp    = (ch == rcp_pkg::CH_LAMP);
	assign req        = tick.relay_request[ch];
	assign test       = tick.cabinet_test[ch];
	assign lact       = tick.latch_active[ch];
	assign keep_latch = !tick.fuzzy_on && tick.latch_force_on[ch];

	assign blackout = is_mist && tick.mist_blackout && !(test && MIST_BYPASS_EN);
	assign lock_d   = cur.lock_until - tick.now_ms;
	assign locked   = (lock_d != 32'd0) && !lock_d[31];

	always_comb begin
		over  = 1'b0;
		under = 1'b0;
		if (is_lamp && tick.temp_valid) begin
			over  = $signed(tick.air_temp) >= $signed(cfg.temp_high);
			under = $signed(tick.air_temp) <= $signed(cfg.temp_low);
		end else if (is_mist && tick.hum_valid) begin
			over  = tick.air_hum >= cfg.hum_high;
			under = tick.air_hum <= cfg.hum_low;
		end
	end

	assign over_kill = over && !test;
	assign on1       = req || (under && !over);
	assign lock_len  = is_lamp ? {1'b0, cfg.lamp_lock_ms} : 32'(MIST_LOCK_MS);

	assign hold_en    = tick.fuzzy_on && !lact;
	assign hold_short = (tick.now_ms - cur.hold_start) < {1'b0, cfg.min_on_ms};
	assign max_hit    = (tick.now_ms - cur.on_start) >= {1'b0, cfg.max_on_ms};

	always_comb begin
		idle             = cur;
		idle.chan_on     = 1'b0;
		idle.on_start    = '0;
		idle.hold_active = 1'b0;
		idle.hold_start  = '0;

		norm = cur;
		on2  = on1;
		if (!hold_en) begin
			norm.hold_active = 1'b0;
			norm.hold_start  = '0;
		end else if (on1 && !cur.hold_active) begin
			norm.hold_active = 1'b1;
			norm.hold_start  = tick.now_ms;
		end else if (!on1 && cur.hold_active && hold_short) begin
			on2 = 1'b1;
		end else if (!on1) begin
			norm.hold_active = 1'b0;
			norm.hold_start  = '0;
		end

		norm_drive = 1'b0;
		norm_clear = 1'b0;
		if (on2) begin
			if (!cur.chan_on) begin
				norm.chan_on  = 1'b1;
				norm.on_start = tick.now_ms;
				norm_drive    = 1'b1;
			end else if (max_hit) begin
				norm            = idle;
				norm.lock_until = tick.now_ms + {1'b0, cfg.cooldown_ms};
				norm_clear      = !keep_latch;
			end else begin
				norm_drive = 1'b1;
			end
		end else begin
			norm.chan_on  = 1'b0;
			norm.on_start = '0;
		end

		res_drive = 1'b0;
		if (blackout) begin
			nxt       = idle;
			res_clear = 1'b1;
		end else if (locked) begin
			nxt       = idle;
			res_clear = !keep_latch;
		end else if (over_kill) begin
			nxt            = idle;
			nxt.lock_until = tick.now_ms + lock_len;
			res_clear      = 1'b1;
		end else begin
			nxt       = norm;
			res_clear = norm_clear;
			res_drive = norm_drive;
		end
	end

	assign new_d    = nxt.lock_until - tick.now_ms;
	assign res_lock = (new_d != 32'd0) && !new_d[31];
	assign res      = '{drive: res_drive, clear: res_clear, locked: res_lock};

endmodule

FILE: rtl/relay_channel_protector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_channel_protector_core
// Relay protection for mist, lamp and two further channels, one channel per
// cycle while the result is not stalled, against a four-entry state memory.
// ----------------------------------------------------------------------------
//  channel   handshake                     payload
//  tick      tick_valid / tick_ready       tick   (rcp_pkg::tick_t)
//  result    result_valid / result_ready   result (rcp_pkg::result_t)
//  config    psel / penable / pwrite       paddr, pwdata, prdata (APB)
//
//  Channels go one per cycle, unless the result stalls, through the one-read
//  one-write state memory and the rule stage that writes it back. The next
//  tick transfer is taken in the cycle the last channel is read, before the
//  last tick is through. The result is registered once the last channel has
//  passed rdata_s1 and the rule stage. Reset clears all channel state through
//  entry valid bits. A stalled result holds the memory read and rule stage.
// ----------------------------------------------------------------------------
module relay_channel_protector_core #(
	parameter int unsigned MIST_LOCK_MS   = rcp_pkg::MIST_LOCK_MS_DEF,
	parameter bit          MIST_BYPASS_EN = rcp_pkg::MIST_BYPASS_EN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         tick_valid,
	output logic                         tick_ready,
	input  rcp_pkg::tick_t               tick,
	output logic                         result_valid,
	input  logic                         result_ready,
	output rcp_pkg::result_t             result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rcp_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	rcp_pkg::cfg_t                 cfg_q;
	rcp_pkg::reg_idx_t             reg_idx;
	rcp_pkg::tick_t                item_q, item_s1;
	logic                          busy_q;
	logic [rcp_pkg::CH_W-1:0]      ch_q, ch_s1;
	logic                          valid_s1, rvld_s1;
	rcp_pkg::chan_state_t          rdata_s1, cur_st, nxt_st;
	rcp_pkg::chan_state_t          mem_q [rcp_pkg::NUM_CH];
	logic [rcp_pkg::NUM_CH-1:0]    ent_vld_q;
	rcp_pkg::chan_res_t            ch_res;
	logic [rcp_pkg::NUM_CH-1:0]    drive_q, clear_q, lock_q;
	logic [rcp_pkg::NUM_CH-1:0]    drive_v, clear_v, lock_v;
	logic                          last_s1, advance, issue, wr_en;
	logic                          result_valid_q;
	rcp_pkg::result_t              result_q;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = rcp_pkg::reg_idx_t'(paddr[rcp_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_high    <= rcp_pkg::TEMP_HIGH_RST;
			cfg_q.temp_low     <= rcp_pkg::TEMP_LOW_RST;
			cfg_q.hum_high     <= rcp_pkg::HUM_HIGH_RST;
			cfg_q.hum_low      <= rcp_pkg::HUM_LOW_RST;
			cfg_q.max_on_ms    <= rcp_pkg::MAX_ON_RST;
			cfg_q.cooldown_ms  <= rcp_pkg::COOLDOWN_RST;
			cfg_q.min_on_ms    <= rcp_pkg::MIN_ON_RST;
			cfg_q.lamp_lock_ms <= rcp_pkg::LAMP_LOCK_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				rcp_pkg::REG_TEMP_HIGH: cfg_q.temp_high    <= pwdata[11:0];
				rcp_pkg::REG_TEMP_LOW:  cfg_q.temp_low     <= pwdata[11:0];
				rcp_pkg::REG_HUM_HIGH:  cfg_q.hum_high     <= pwdata[10:0];
				rcp_pkg::REG_HUM_LOW:   cfg_q.hum_low      <= pwdata[10:0];
				rcp_pkg::REG_MAX_ON:    cfg_q.max_on_ms    <= pwdata[30:0];
				rcp_pkg::REG_COOLDOWN:  cfg_q.cooldown_ms  <= pwdata[30:0];
				rcp_pkg::REG_MIN_ON:    cfg_q.min_on_ms    <= pwdata[30:0];
				rcp_pkg::REG_LAMP_LOCK: cfg_q.lamp_lock_ms <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rcp_pkg::REG_TEMP_HIGH: prdata = {20'd0, cfg_q.temp_high};
			rcp_pkg::REG_TEMP_LOW:  prdata = {20'd0, cfg_q.temp_low};
			rcp_pkg::REG_HUM_HIGH:  prdata = {21'd0, cfg_q.hum_high};
			rcp_pkg::REG_HUM_LOW:   prdata = {21'd0, cfg_q.hum_low};
			rcp_pkg::REG_MAX_ON:    prdata = {1'b0, cfg_q.max_on_ms};
			rcp_pkg::REG_COOLDOWN:  prdata = {1'b0, cfg_q.cooldown_ms};
			rcp_pkg::REG_MIN_ON:    prdata = {1'b0, cfg_q.min_on_ms};
			rcp_pkg::REG_LAMP_LOCK: prdata = {1'b0, cfg_q.lamp_lock_ms};
			default:                prdata = '0;
		endcase
	end

	// channel sequencing
	assign last_s1    = (ch_s1 == rcp_pkg::CH_LAST);
	assign advance    = !(valid_s1 && last_s1 && result_valid_q && !result_ready);
	assign issue      = busy_q && advance;
	assign wr_en      = valid_s1 && advance;
	assign tick_ready = !busy_q || ((ch_q == rcp_pkg::CH_LAST) && advance);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ch_q   <= '0;
		end else if (tick_valid && tick_ready) begin
			busy_q <= 1'b1;
			ch_q   <= '0;
		end else if (issue) begin
			ch_q <= ch_q + 1'b1;
			if (ch_q == rcp_pkg::CH_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			item_q <= tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ch_s1    <= '0;
			rvld_s1  <= 1'b0;
		end else if (advance) begin
			valid_s1 <= issue;
			ch_s1    <= ch_q;
			rvld_s1  <= ent_vld_q[ch_q];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= item_q;
		end
	end

	// state memory
	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem_q[ch_q];
		end
		if (wr_en) begin
			mem_q[ch_s1] <= nxt_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (wr_en) begin
			ent_vld_q[ch_s1] <= 1'b1;
		end
	end

	assign cur_st = rvld_s1 ? rdata_s1 : '0;

	rcp_chan_eval #(
		.MIST_LOCK_MS   (MIST_LOCK_MS),
		.MIST_BYPASS_EN (MIST_BYPASS_EN)
	) u_eval (
		.tick (item_s1),
		.ch   (ch_s1),
		.cfg  (cfg_q),
		.cur  (cur_st),
		.nxt  (nxt_st),
		.res  (ch_res)
	);

	// collect channel bits
	always_comb begin
		drive_v        = drive_q;
		clear_v        = clear_q;
		lock_v         = lock_q;
		drive_v[ch_s1] = ch_res.drive;
		clear_v[ch_s1] = ch_res.clear;
		lock_v[ch_s1]  = ch_res.locked;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			drive_q <= drive_v;
			clear_q <= clear_v;
			lock_q  <= lock_v;
		end
		if (wr_en && last_s1) begin
			result_q.relay_drive <= drive_v;
			result_q.latch_clear <= clear_v;
			result_q.lock_flags  <= lock_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (wr_en && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: dv/relay_channel_protector_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_channel_protector_core_tb
// Drives protection ticks through the core under random valid/ready gaps and
// APB register settings. A scoreboard predicts every relay result from its
// own copy of the per-channel state and checks each result transfer in order.
// ----------------------------------------------------------------------------
import rcp_pkg::*;

class relay_scoreboard;
	cfg_t        cfg;
	chan_state_t chan[NUM_CH];
	result_t     expected_q[$];
	int          errors;

	function new();
		cfg = '{TEMP_HIGH_RST, TEMP_LOW_RST, HUM_HIGH_RST, HUM_LOW_RST,
			MAX_ON_RST, COOLDOWN_RST, MIN_ON_RST, LAMP_LOCK_RST};
		for (int c = 0; c < NUM_CH; c++) chan[c] = '0;
		errors = 0;
	endfunction

	function void write_reg(reg_idx_t idx, logic [31:0] v);
		case (idx)
			REG_TEMP_HIGH: cfg.temp_high    = v[11:0];
			REG_TEMP_LOW:  cfg.temp_low     = v[11:0];
			REG_HUM_HIGH:  cfg.hum_high     = v[10:0];
			REG_HUM_LOW:   cfg.hum_low      = v[10:0];
			REG_MAX_ON:    cfg.max_on_ms    = v[30:0];
			REG_COOLDOWN:  cfg.cooldown_ms  = v[30:0];
			REG_MIN_ON:    cfg.min_on_ms    = v[30:0];
			REG_LAMP_LOCK: cfg.lamp_lock_ms = v[30:0];
			default: ;
		endcase
	endfunction

	function bit lock_live(logic [31:0] now, logic [31:0] lock_end);
		logic [31:0] d;
		d = lock_end - now;
		return (d != 32'd0) && !d[31];
	endfunction

	function void idle_chan(int c);
		chan[c].chan_on     = 1'b0;
		chan[c].on_start    = '0;
		chan[c].hold_active = 1'b0;
		chan[c].hold_start  = '0;
	endfunction

	function void note_tick(tick_t t);
		result_t            exp_r;
		logic [31:0]        now;
		logic signed [11:0] temp, th, tl;
		bit                 on, test, keep;
		exp_r = '0;
		now   = t.now_ms;
		temp  = t.air_temp;
		th    = cfg.temp_high;
		tl    = cfg.temp_low;
		for (int c = 0; c < NUM_CH; c++) begin
			on   = t.relay_request[c];
			test = t.cabinet_test[c];
			keep = !t.fuzzy_on && t.latch_force_on[c];
			if (c == CH_MIST && t.mist_blackout && !(test && MIST_BYPASS_EN_DEF)) begin
				exp_r.latch_clear[c] = 1'b1;
				idle_chan(c);
				continue;
			end
			if (lock_live(now, chan[c].lock_until)) begin
				if (!keep) exp_r.latch_clear[c] = 1'b1;
				idle_chan(c);
				continue;
			end
			if (c == CH_LAMP && t.temp_valid) begin
				if (temp >= th) begin
					if (!test) begin
						exp_r.latch_clear[c] = 1'b1;
						chan[c].lock_until = now + {1'b0, cfg.lamp_lock_ms};
						idle_chan(c);
						continue;
					end
				end else if (temp <= tl) begin
					on = 1'b1;
				end
			end else if (c == CH_MIST && t.hum_valid) begin
				if (t.air_hum >= cfg.hum_high) begin
					if (!test) begin
						exp_r.latch_clear[c] = 1'b1;
						chan[c].lock_until = now + MIST_LOCK_MS_DEF;
						idle_chan(c);
						continue;
					end
				end else if (t.air_hum <= cfg.hum_low) begin
					on = 1'b1;
				end
			end
			if (!(t.fuzzy_on && !t.latch_active[c])) begin
				chan[c].hold_active = 1'b0;
				chan[c].hold_start  = '0;
			end else if (on && !chan[c].hold_active) begin
				chan[c].hold_active = 1'b1;
				chan[c].hold_start  = now;
			end else if (!on && chan[c].hold_active &&
					(now - chan[c].hold_start) < {1'b0, cfg.min_on_ms}) begin
				on = 1'b1;
			end else if (!on) begin
				chan[c].hold_active = 1'b0;
				chan[c].hold_start  = '0;
			end
			if (on) begin
				if (!chan[c].chan_on) begin
					chan[c].chan_on  = 1'b1;
					chan[c].on_start = now;
				end else if ((now - chan[c].on_start) >= {1'b0, cfg.max_on_ms}) begin
					on = 1'b0;
					if (!keep) exp_r.latch_clear[c] = 1'b1;
					chan[c].lock_until = now + {1'b0, cfg.cooldown_ms};
					idle_chan(c);
				end
			end else begin
				chan[c].chan_on  = 1'b0;
				chan[c].on_start = '0;
			end
			exp_r.relay_drive[c] = on;
		end
		for (int c = 0; c < NUM_CH; c++)
			exp_r.lock_flags[c] = lock_live(now, chan[c].lock_until);
		expected_q.push_back(exp_r);
	endfunction

	task report(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	task check_result(result_t got);
		result_t want;
		if (expected_q.size() == 0) begin
			report($sformatf("result %h with no tick pending", got));
			return;
		end
		want = expected_q.pop_front();
		if (got.relay_drive !== want.relay_drive)
			report($sformatf("relay_drive %h, want %h", got.relay_drive, want.relay_drive));
		if (got.latch_clear !== want.latch_clear)
			report($sformatf("latch_clear %h, want %h", got.latch_clear, want.latch_clear));
		if (got.lock_flags !== want.lock_flags)
			report($sformatf("lock_flags %h, want %h", got.lock_flags, want.lock_flags));
	endtask
endclass

module relay_channel_protector_core_tb;

	localparam int unsigned CYCLE_LIMIT = 400000;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              tick_valid   = 1'b0;
	logic              tick_ready;
	tick_t             tick         = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	result_t           result;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [31:0]       pwdata       = '0;
	logic [31:0]       prdata;
	logic              pready;

	relay_scoreboard   sb;
	bit                tx_idle_en   = 1'b1;
	bit                rx_idle_en   = 1'b1;
	int unsigned       cycle_count  = 0;
	logic [31:0]       sim_now      = '0;

	relay_channel_protector_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_ready   (tick_ready),
		.tick         (tick),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) sb.check_result(result);
	end

	initial begin
		forever begin
			@(negedge clk);
			if (rx_idle_en && $urandom_range(0, 9) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			result_ready <= 1'b1;
		end
	end

	task automatic push_tick(input tick_t t);
		@(negedge clk);
		tick_valid <= 1'b1;
		tick       <= t;
		do @(posedge clk); while (!tick_ready);
		sb.note_tick(t);
	endtask

	task automatic tx_gap(input int unsigned n);
		@(negedge clk);
		tick_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// hold until every pending result has been taken
	task automatic drain();
		@(negedge clk);
		tick_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, v);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic load_config(input logic [31:0] th, input logic [31:0] tl,
			input logic [31:0] hh, input logic [31:0] hl, input logic [31:0] max_on,
			input logic [31:0] cool, input logic [31:0] min_on, input logic [31:0] lamp_lock);
		apb_write(REG_TEMP_HIGH, th);
		apb_write(REG_TEMP_LOW, tl);
		apb_write(REG_HUM_HIGH, hh);
		apb_write(REG_HUM_LOW, hl);
		apb_write(REG_MAX_ON, max_on);
		apb_write(REG_COOLDOWN, cool);
		apb_write(REG_MIN_ON, min_on);
		apb_write(REG_LAMP_LOCK, lamp_lock);
	endtask

	function automatic tick_t mk(input logic [31:0] now, input logic fuzzy,
			input logic signed [11:0] temp, input logic tv, input logic [10:0] hum,
			input logic hv, input logic blackout, input logic [3:0] req,
			input logic [3:0] lact, input logic [3:0] lfon, input logic [3:0] ctest);
		tick_t t;
		t.now_ms         = now;
		t.fuzzy_on       = fuzzy;
		t.air_temp       = temp;
		t.temp_valid     = tv;
		t.air_hum        = hum;
		t.hum_valid      = hv;
		t.mist_blackout  = blackout;
		t.relay_request  = req;
		t.latch_active   = lact;
		t.latch_force_on = lfon;
		t.cabinet_test   = ctest;
		return t;
	endfunction

	function automatic tick_t rand_tick(input logic [31:0] now);
		tick_t              t;
		logic signed [11:0] th_s, tl_s;
		int                 th_i, tl_i, hh_i, hl_i, lo, hi, v;
		th_s = sb.cfg.temp_high;
		tl_s = sb.cfg.temp_low;
		th_i = int'(th_s);
		tl_i = int'(tl_s);
		hh_i = int'({21'd0, sb.cfg.hum_high});
		hl_i = int'({21'd0, sb.cfg.hum_low});
		case ($urandom_range(0, 9))
			0: v = $urandom;
			1: v = th_i + $urandom_range(0, 6) - 3;
			2: v = tl_i + $urandom_range(0, 6) - 3;
			default: begin
				lo = tl_i - 100;
				hi = th_i - 1;
				v  = (hi < lo) ? $urandom : lo + $urandom_range(0, hi - lo);
			end
		endcase
		t.air_temp = v[11:0];
		case ($urandom_range(0, 9))
			0: v = $urandom;
			1: v = hh_i + $urandom_range(0, 6) - 3;
			2: v = hl_i + $urandom_range(0, 6) - 3;
			default: begin
				lo = hl_i;
				hi = hh_i - 1;
				v  = (hi < lo) ? $urandom : lo + $urandom_range(0, hi - lo);
			end
		endcase
		t.air_hum        = v[10:0];
		t.now_ms         = now;
		t.fuzzy_on       = 1'($urandom_range(0, 1));
		t.temp_valid     = $urandom_range(0, 7) != 0;
		t.hum_valid      = $urandom_range(0, 7) != 0;
		t.mist_blackout  = $urandom_range(0, 7) == 0;
		t.relay_request  = 4'($urandom);
		t.latch_active   = ($urandom_range(0, 3) != 0) ? 4'($urandom & $urandom) : 4'($urandom);
		t.latch_force_on = 4'($urandom);
		t.cabinet_test   = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'h0;
		return t;
	endfunction

	task automatic run_phase(input int n, input int unsigned step_max, input int pause_at);
		for (int i = 0; i < n; i++) begin
			if (i == pause_at) drain();
			if (tx_idle_en && $urandom_range(0, 9) == 0) tx_gap($urandom_range(1, 15));
			case ($urandom_range(0, 63))
				0:       sim_now += $urandom;
				1, 2, 3: sim_now += $urandom_range(0, 1000000);
				default: sim_now += $urandom_range(0, step_max);
			endcase
			push_tick(rand_tick(sim_now));
		end
		drain();
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_tick(mk(32'd0, 0, 12'sd0, 0, 11'd0, 0, 0, 4'h0, 4'h0, 4'h0, 4'h0));
		push_tick(mk(32'd100, 0, 12'sd400, 1, 11'd1400, 1, 0, 4'hF, 4'h0, 4'h0, 4'h0));
		push_tick(mk(32'd150, 0, 12'sd2047, 1, 11'd2047, 1, 0, 4'h0, 4'h0, 4'h0, 4'h3));
		push_tick(mk(32'd160, 0, -12'sd2048, 1, 11'd0, 1, 0, 4'h0, 4'h0, 4'h0, 4'h0));
		push_tick(mk(32'd170, 0, -12'sd2048, 0, 11'd0, 0, 0, 4'h0, 4'h0, 4'h0, 4'h0));
		push_tick(mk(32'd200, 0, 12'sd400, 1, 11'd1400, 1, 1, 4'h1, 4'h0, 4'h0, 4'h0));
		push_tick(mk(32'd210, 0, 12'sd400, 1, 11'd1400, 1, 1, 4'h1, 4'h0, 4'h0, 4'h1));
		push_tick(mk(32'd300, 1, 12'sd400, 1, 11'd1400, 1, 0, 4'h4, 4'h0, 4'h0, 4'h0));
		push_tick(mk(32'd310, 1, 12'sd400, 1, 11'd1400, 1, 0, 4'h0, 4'h0, 4'h0, 4'h0));
		push_tick(mk(32'd10300, 1, 12'sd400, 1, 11'd1400, 1, 0, 4'h0, 4'h0, 4'h0, 4'h0));
		push_tick(mk(32'd10310, 1, 12'sd400, 1, 11'd1400, 1, 0, 4'h4, 4'h4, 4'h0, 4'h0));
		push_tick(mk(32'd10320, 1, 12'sd400, 1, 11'd1400, 1, 0, 4'h0, 4'h4, 4'h0, 4'h0));
		push_tick(mk(32'd20000, 0, 12'sd400, 1, 11'd1400, 1, 0, 4'h8, 4'h0, 4'h0, 4'h0));
		push_tick(mk(32'd200000, 0, 12'sd400, 1, 11'd1400, 1, 0, 4'h8, 4'h0, 4'h0, 4'h0));
		push_tick(mk(32'd210000, 0, 12'sd400, 1, 11'd1400, 1, 0, 4'h8, 4'h8, 4'h8, 4'h0));
		push_tick(mk(32'd230000, 0, 12'sd400, 1, 11'd1400, 1, 0, 4'h8, 4'h0, 4'h0, 4'h0));
		push_tick(mk(32'd240000, 0, 12'sd480, 1, 11'd1400, 1, 0, 4'h2, 4'h0, 4'h0, 4'h0));
		push_tick(mk(32'd240010, 0, 12'sd400, 1, 11'd1520, 1, 0, 4'h1, 4'h0, 4'h0, 4'h0));
		push_tick(mk(32'd250000, 1, 12'sd400, 1, 11'd1400, 1, 0, 4'hF, 4'hF, 4'hF, 4'h0));
		push_tick(mk(32'hFFFF_FFFF, 1, -12'sd2048, 1, 11'd2047, 1, 1, 4'hF, 4'hF, 4'hF, 4'hF));
		push_tick(mk(32'h0000_0010, 0, 12'sd0, 0, 11'd0, 0, 0, 4'hF, 4'h0, 4'h0, 4'h0));
		drain();

		sim_now = $urandom;
		load_config(480, 288, 1520, 1280, 60, 40, 25, 80);
		run_phase(200, 10, 100);

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b0;
		load_config(-800, -800, 0, 0, 1, 0, 0, 0);
		run_phase(200, 3, -1);

		tx_idle_en = 1'b0;
		rx_idle_en = 1'b1;
		load_config(1600, -800, 1600, 1600, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF);
		run_phase(200, 32'h4000_0000, -1);

		rx_idle_en = 1'b0;
		load_config(400, 100, 1400, 1000, 0, 20, 10, 30);
		run_phase(200, 8, -1);

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		load_config($urandom, $urandom, $urandom, $urandom,
			($urandom & 32'h8000_0000) | $urandom_range(0, 200),
			($urandom & 32'h8000_0000) | $urandom_range(0, 200),
			($urandom & 32'h8000_0000) | $urandom_range(0, 200),
			($urandom & 32'h8000_0000) | $urandom_range(0, 200));
		run_phase(200, 20, -1);

		load_config(480, 288, 1520, 1280, 180000, 30000, 10000, 300000);
		run_phase(200, 20000, -1);

		load_config(2047, -2048, 2047, 0, $urandom_range(0, 2000), $urandom_range(0, 2000),
			$urandom_range(0, 2000), $urandom_range(0, 2000));
		run_phase(200, 300, -1);

		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		load_config(700, 0, 1200, 400, 100, 50, 30, 120);
		run_phase(210, 12, -1);

		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/rcp_pkg.sv
rtl/rcp_chan_eval.sv
rtl/relay_channel_protector_core.sv
dv/relay_channel_protector_core_tb.sv
